>>> rtl/core/rope_pkg.sv
package rope_pkg;

	localparam int RotarySpanDefault = 64;
	localparam int PairCountDefault  = 32;
	localparam int BaseThetaDefault  = 10000;

	localparam int RomDepth = 128;

	localparam logic signed [31:0] HalfPiQ30 = 32'sd1686629713;
	localparam longint unsigned InvTwoPiQ32 = 64'd683565276;

	localparam logic signed [31:0] SinC0 = 32'sd1073738173;
	localparam logic signed [31:0] SinC1 = -32'sd178937185;
	localparam logic signed [31:0] SinC2 = 32'sd8918811;
	localparam logic signed [31:0] SinC3 = -32'sd197171;
	localparam logic signed [31:0] CosC0 = 32'sd1073741115;
	localparam logic signed [31:0] CosC1 = -32'sd536861517;
	localparam logic signed [31:0] CosC2 = 32'sd44734275;
	localparam logic signed [31:0] CosC3 = -32'sd1433735;
	localparam logic signed [31:0] CosC4 = 32'sd24846;

	localparam logic [0:0] RegTokenPosition = 1'b0;

	typedef logic [31:0] rom_t [RomDepth];

	// floor square root, one result bit per pass
	function automatic longint unsigned isqrt64(input longint unsigned v_in);
		longint unsigned v;
		longint unsigned res;
		longint unsigned bitv;
		v = v_in;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// floor quotient by shift and subtract, small divisor
	function automatic longint unsigned div_floor(input longint unsigned num,
		input longint unsigned den);
		longint unsigned quo;
		longint unsigned rest;
		quo = 0;
		rest = 0;
		for (int k = 63; k >= 0; k--) begin
			rest = {rest[62:0], num[k]};
			if (rest >= den) begin
				rest = rest - den;
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

	// frequency table, Q0.32 fraction of a turn per position
	function automatic rom_t build_rom(input int span, input int count, input int theta_in);
		rom_t rom;
		longint unsigned fac [31];
		longint unsigned theta;
		longint unsigned m;
		longint unsigned frac;
		longint unsigned lg;
		longint unsigned y;
		longint unsigned yi;
		longint unsigned yf;
		longint unsigned p;
		longint unsigned v;
		int n;
		theta = longint'(theta_in);
		fac[0] = 0;
		fac[1] = isqrt64(64'd1 << 63);
		for (int k = 2; k <= 30; k++) fac[k] = isqrt64(fac[k - 1] << 32);
		n = 0;
		while (n < 40 && (theta >> (n + 1)) != 0) n++;
		m = (theta << 30) >> n;
		frac = 0;
		for (int k = 1; k <= 30; k++) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				frac = frac | (64'd1 << (30 - k));
				m = m >> 1;
			end
		end
		lg = (longint'(n) << 30) | frac;
		for (int i = 0; i < RomDepth; i++) begin
			if (i >= count) begin
				rom[i] = '0;
			end else begin
				y = div_floor(64'd2 * longint'(i) * lg, longint'(span));
				yi = y >> 30;
				yf = y & ((64'd1 << 30) - 1);
				p = 64'd1 << 32;
				for (int k = 1; k <= 30; k++)
					if (((yf >> (30 - k)) & 64'd1) != 0) p = (p * fac[k] + (64'd1 << 31)) >> 32;
				v = p * InvTwoPiQ32;
				if (yi > 30) rom[i] = '0;
				else rom[i] = 32'((v + (64'd1 << (31 + yi))) >> (32 + yi));
			end
		end
		return rom;
	endfunction

	// shift right by 30, round half away from zero
	function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
		logic signed [63:0] mag;
		mag = (x < 0) ? -x : x;
		mag = (mag + 64'sd536870912) >>> 30;
		return (x < 0) ? -mag : mag;
	endfunction

endpackage

>>> rtl/core/rope_datapath.sv
module rope_datapath #(
	parameter int ROTARY_SPAN = rope_pkg::RotarySpanDefault,
	parameter int PAIR_COUNT  = rope_pkg::PairCountDefault,
	parameter int BASE_THETA  = rope_pkg::BaseThetaDefault
) (
	input  logic               clk,
	input  logic               advance,
	input  logic [15:0]        token_position,
	input  logic               mode,
	input  logic [6:0]         pair_index,
	input  logic signed [15:0] first_value,
	input  logic signed [15:0] second_value,
	input  logic [5:0]         head_tag,
	output logic [5:0]         tag_out,
	output logic signed [15:0] first_out,
	output logic signed [15:0] second_out,
	output logic               clipped
);

	localparam rope_pkg::rom_t FreqRom = rope_pkg::build_rom(ROTARY_SPAN, PAIR_COUNT, BASE_THETA);
	localparam int Depth = 10;

	typedef struct packed {
		logic [5:0]         tag;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               bypass;
	} side_t;

	side_t side_s [1:Depth];
	logic [1:0] q_s [3:Depth - 1];

	logic [31:0]        freq_s1;
	logic [31:0]        phase_s2;
	logic signed [63:0] prod_s3;
	logic signed [31:0] rad_s4, rad_s5, rad_s6, rad_s7, rad_s8;
	logic signed [31:0] r2_s5, r2_s6, r2_s7, r2_s8;
	logic signed [31:0] ps_s6, ps_s7, ps_s8, ps_s9;
	logic signed [31:0] pc_s6, pc_s7, pc_s8, pc_s9;
	logic signed [47:0] ac_s10, bs_s10, bc_s10, as_s10;

	logic [47:0]        phase_full;
	logic [31:0]        q_sum;
	logic [31:0]        rem_u;
	logic signed [29:0] rem;
	logic signed [63:0] rad_full, r2_full;
	logic signed [63:0] ps6_m, pc6_m, ps7_m, pc7_m, ps8_m, pc8_m, ps9_m, pc9_m;
	logic signed [31:0] sv, cv;
	logic signed [63:0] d_first, d_second, t_first, t_second;
	logic signed [15:0] f_sat, s_sat;
	logic               f_clip, s_clip;

	always_comb begin
		phase_full = freq_s1 * token_position;
		q_sum = phase_s2 + 32'h2000_0000;
		rem_u = phase_s2 - {q_sum[31:30], 30'b0};
		rem = rem_u[29:0];
		rad_full = rope_pkg::rnd30(prod_s3);
		r2_full = rope_pkg::rnd30(rad_s4 * rad_s4);
		ps6_m = rope_pkg::rnd30(r2_s5 * rope_pkg::SinC3) + rope_pkg::SinC2;
		pc6_m = rope_pkg::rnd30(r2_s5 * rope_pkg::CosC4) + rope_pkg::CosC3;
		ps7_m = rope_pkg::rnd30(r2_s6 * ps_s6) + rope_pkg::SinC1;
		pc7_m = rope_pkg::rnd30(r2_s6 * pc_s6) + rope_pkg::CosC2;
		ps8_m = rope_pkg::rnd30(r2_s7 * ps_s7) + rope_pkg::SinC0;
		pc8_m = rope_pkg::rnd30(r2_s7 * pc_s7) + rope_pkg::CosC1;
		ps9_m = rope_pkg::rnd30(rad_s8 * ps_s8);
		pc9_m = rope_pkg::rnd30(r2_s8 * pc_s8) + rope_pkg::CosC0;
		// quadrant rotation of sine and cosine
		case (q_s[Depth - 1])
			2'd0: begin sv = ps_s9;  cv = pc_s9;  end
			2'd1: begin sv = pc_s9;  cv = -ps_s9; end
			2'd2: begin sv = -ps_s9; cv = -pc_s9; end
			default: begin sv = -pc_s9; cv = ps_s9; end
		endcase
		d_first = ac_s10 - bs_s10;
		d_second = bc_s10 + as_s10;
		t_first = rope_pkg::rnd30(d_first);
		t_second = rope_pkg::rnd30(d_second);
		f_clip = 1'b1;
		s_clip = 1'b1;
		if (t_first > 64'sd32767) f_sat = 16'sh7fff;
		else if (t_first < -64'sd32768) f_sat = 16'sh8000;
		else begin
			f_sat = t_first[15:0];
			f_clip = 1'b0;
		end
		if (t_second > 64'sd32767) s_sat = 16'sh7fff;
		else if (t_second < -64'sd32768) s_sat = 16'sh8000;
		else begin
			s_sat = t_second[15:0];
			s_clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s[1] <= '{tag: head_tag, a: first_value, b: second_value,
				bypass: mode | (32'(pair_index) >= 32'(PAIR_COUNT))};
			for (int i = 2; i <= Depth; i++) side_s[i] <= side_s[i - 1];
			freq_s1 <= FreqRom[pair_index];
			phase_s2 <= phase_full[31:0];
			prod_s3 <= rem * rope_pkg::HalfPiQ30;
			q_s[3] <= q_sum[31:30];
			for (int i = 4; i <= Depth - 1; i++) q_s[i] <= q_s[i - 1];
			rad_s4 <= rad_full[31:0];
			rad_s5 <= rad_s4;
			rad_s6 <= rad_s5;
			rad_s7 <= rad_s6;
			rad_s8 <= rad_s7;
			r2_s5 <= r2_full[31:0];
			r2_s6 <= r2_s5;
			r2_s7 <= r2_s6;
			r2_s8 <= r2_s7;
			ps_s6 <= ps6_m[31:0];
			pc_s6 <= pc6_m[31:0];
			ps_s7 <= ps7_m[31:0];
			pc_s7 <= pc7_m[31:0];
			ps_s8 <= ps8_m[31:0];
			pc_s8 <= pc8_m[31:0];
			ps_s9 <= ps9_m[31:0];
			pc_s9 <= pc9_m[31:0];
			ac_s10 <= side_s[Depth - 1].a * cv;
			bs_s10 <= side_s[Depth - 1].b * sv;
			bc_s10 <= side_s[Depth - 1].b * cv;
			as_s10 <= side_s[Depth - 1].a * sv;
			tag_out <= side_s[Depth].tag;
			if (side_s[Depth].bypass) begin
				first_out <= side_s[Depth].a;
				second_out <= side_s[Depth].b;
				clipped <= 1'b0;
			end else begin
				first_out <= f_sat;
				second_out <= s_sat;
				clipped <= f_clip | s_clip;
			end
		end
	end

endmodule

>>> rtl/core/rotary_position_embedding_top.sv
// an input transfer passes through every pipeline stage to its result on the output register
// throughput: one pair per cycle, limited by nothing but the output side stalling
// the whole pipeline advances together; a stall at the output holds every stage
// reset (arst_n low) clears all stage valid bits and token_position to 0
// the frequency table is a constant rom, so no clearing pass follows reset
module rotary_position_embedding_top #(
	parameter int ROTARY_SPAN = rope_pkg::RotarySpanDefault,
	parameter int PAIR_COUNT  = rope_pkg::PairCountDefault,
	parameter int BASE_THETA  = rope_pkg::BaseThetaDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [6:0]         pair_index,
	input  logic signed [15:0] first_value,
	input  logic signed [15:0] second_value,
	input  logic [5:0]         head_tag,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         tag_out,
	output logic signed [15:0] first_out,
	output logic signed [15:0] second_out,
	output logic               clipped
);

	localparam int Stages = 11;

	logic [15:0]       token_position_q;
	logic [Stages-1:0] valid_q;
	logic              advance;

	// the pipeline moves whenever the output register is empty or being drained
	assign advance = !(valid_q[Stages-1] && out_stall);
	assign in_stall = !advance;
	assign out_valid = valid_q[Stages-1];
	assign pready = 1'b1;

	// register index is the word address; only token_position exists
	assign prdata = (paddr[2] == rope_pkg::RegTokenPosition) ? {16'b0, token_position_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_position_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == rope_pkg::RegTokenPosition) begin
			token_position_q <= pwdata[15:0];
		end
	end

	// valid bits travel beside the data, one per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (advance) begin
			valid_q <= {valid_q[Stages-2:0], in_valid};
		end
	end

	rope_datapath #(
		.ROTARY_SPAN(ROTARY_SPAN),
		.PAIR_COUNT(PAIR_COUNT),
		.BASE_THETA(BASE_THETA)
	) u_datapath (
		.clk(clk),
		.advance(advance),
		.token_position(token_position_q),
		.mode(mode),
		.pair_index(pair_index),
		.first_value(first_value),
		.second_value(second_value),
		.head_tag(head_tag),
		.tag_out(tag_out),
		.first_out(first_out),
		.second_out(second_out),
		.clipped(clipped)
	);

endmodule

>>> rtl/core/rope_chk.sv
module rope_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] first_out,
	input logic signed [15:0] second_out,
	input logic               clipped
);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(first_out) && $stable(second_out))
		else $error("result changed while stalled");

	// input only stalls behind a stalled full output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a clipped result carries a rail value
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> first_out == 16'sh7fff || first_out == 16'sh8000 ||
			second_out == 16'sh7fff || second_out == 16'sh8000)
		else $error("clip flag without saturated value");

	// nothing comes out right after reset
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind rotary_position_embedding_top rope_chk u_rope_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.first_out(first_out),
	.second_out(second_out),
	.clipped(clipped)
);

>>> tb/tb_rotary_position_embedding_top.sv
`timescale 1ns / 100ps

module tb_rotary_position_embedding_top;

	localparam int Span      = 64;
	localparam int Pairs     = 32;
	localparam int Theta     = 10000;
	localparam int IdleLimit = 5000;
	localparam int Latency   = 11;
	localparam logic [2:0] AddrTokenPos = {rope_pkg::RegTokenPosition, 2'b00};
	localparam logic [2:0] AddrUnused   = 3'd4;

	typedef struct packed {
		logic              mode;
		logic [6:0]        pair_index;
		logic signed [15:0] first_value;
		logic signed [15:0] second_value;
		logic [5:0]        head_tag;
	} pair_t;

	typedef struct packed {
		logic [5:0]         tag;
		logic signed [15:0] first;
		logic signed [15:0] second;
		logic               clip;
	} rotated_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [6:0] pair_index = '0;
	logic signed [15:0] first_value = '0, second_value = '0;
	logic [5:0] head_tag = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] tag_out;
	logic signed [15:0] first_out, second_out;
	logic clipped;

	rotary_position_embedding_top dut (.*);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pair_t    pending_pairs [$];
	rotated_t rotations_due [$];
	logic [31:0] turn_rate [128];
	logic [15:0] cur_position = '0;
	bit   in_taken = 0;
	bit   quiet = 0;
	int   in_gap = 0, out_gap = 0;
	int   idle_cycles = 0;
	int   errors = 0;

	// floor square root, bit by bit
	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			b = r | (64'd1 << i);
			if (b * b <= x && b <= 64'hFFFF_FFFF) r = b;
		end
		return r;
	endfunction

	// turns per position for each pair, Q0.32
	task automatic fill_turn_rate();
		longint unsigned halving [31];
		longint unsigned m, fr, lg, y, yi, yf, p, v;
		int n;
		halving[1] = root_floor(64'd1 << 63);
		for (int k = 2; k <= 30; k++) halving[k] = root_floor(halving[k - 1] << 32);
		n = 0;
		while (n < 40 && (longint'(Theta) >> (n + 1)) != 0) n++;
		m = (longint'(Theta) << 30) >> n;
		fr = 0;
		for (int k = 1; k <= 30; k++) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				fr |= 64'd1 << (30 - k);
				m >>= 1;
			end
		end
		lg = (longint'(n) << 30) | fr;
		for (int i = 0; i < 128; i++) begin
			turn_rate[i] = '0;
			if (i < Pairs) begin
				y = (64'd2 * i * lg) / Span;
				yi = y >> 30;
				yf = y & ((64'd1 << 30) - 1);
				p = 64'd1 << 32;
				for (int k = 1; k <= 30; k++)
					if (yf[30 - k]) p = (p * halving[k] + (64'd1 << 31)) >> 32;
				v = p * 64'd683565276;
				if (yi <= 30) turn_rate[i] = 32'((v + (64'd1 << (31 + yi))) >> (32 + yi));
			end
		end
	endtask

	// drop sh bits, round half away from zero
	function automatic longint round_off(input longint x, input int sh);
		longint mag;
		mag = (x < 0) ? -x : x;
		mag = (mag + (64'sd1 << (sh - 1))) >>> sh;
		return (x < 0) ? -mag : mag;
	endfunction

	function automatic longint clamp16(input longint x, inout logic clip);
		if (x > 32767) begin
			clip = 1'b1;
			return 32767;
		end
		if (x < -32768) begin
			clip = 1'b1;
			return -32768;
		end
		return x;
	endfunction

	function automatic rotated_t rotate_pair(input pair_t it);
		rotated_t res;
		logic [31:0] phase, u;
		logic [1:0] quad;
		longint r, rad, r2, ps, pc, sv, cv, a, b;
		logic clip;
		res.tag = it.head_tag;
		res.first = it.first_value;
		res.second = it.second_value;
		res.clip = 1'b0;
		if (it.mode == 1'b0 && it.pair_index < Pairs) begin
			phase = turn_rate[it.pair_index] * cur_position;
			quad = 2'((phase + 32'h2000_0000) >> 30);
			u = phase - {quad, 30'd0};
			r = longint'($signed(u));
			rad = round_off(r * 64'sd1686629713, 30);
			r2 = round_off(rad * rad, 30);
			ps = -64'sd197171;
			ps = 64'sd8918811 + round_off(r2 * ps, 30);
			ps = -64'sd178937185 + round_off(r2 * ps, 30);
			ps = 64'sd1073738173 + round_off(r2 * ps, 30);
			ps = round_off(rad * ps, 30);
			pc = 64'sd24846;
			pc = -64'sd1433735 + round_off(r2 * pc, 30);
			pc = 64'sd44734275 + round_off(r2 * pc, 30);
			pc = -64'sd536861517 + round_off(r2 * pc, 30);
			pc = 64'sd1073741115 + round_off(r2 * pc, 30);
			case (quad)
				2'd0: begin sv = ps; cv = pc; end
				2'd1: begin sv = pc; cv = -ps; end
				2'd2: begin sv = -ps; cv = -pc; end
				default: begin sv = -pc; cv = ps; end
			endcase
			a = it.first_value;
			b = it.second_value;
			clip = 1'b0;
			res.first = 16'(clamp16(round_off(a * cv - b * sv, 30), clip));
			res.second = 16'(clamp16(round_off(b * cv + a * sv, 30), clip));
			res.clip = clip;
		end
		return res;
	endfunction

	// driver: new transfer offered at the falling edge once the old one is taken
	always @(negedge clk) begin
		pair_t it;
		logic v;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 0;
			v = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
			end else if (pending_pairs.size() > 0) begin
				it = pending_pairs.pop_front();
				mode <= it.mode;
				pair_index <= it.pair_index;
				first_value <= it.first_value;
				second_value <= it.second_value;
				head_tag <= it.head_tag;
				v = 1'b1;
				if (!quiet && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 17);
			end
			in_valid <= v;
		end
	end

	// output side stall bursts
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 17);
		end
	end

	// monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		rotated_t want;
		bit moved;
		moved = 0;
		if (arst_n && in_valid && !in_stall) begin
			rotations_due.push_back(rotate_pair({mode, pair_index, first_value,
				second_value, head_tag}));
			in_taken = 1;
			moved = 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			moved = 1;
			if (rotations_due.size() == 0) begin
				$error("result transfer with nothing expected, tag_out %0d", tag_out);
				errors++;
			end else begin
				want = rotations_due.pop_front();
				if (tag_out !== want.tag) begin
					$error("tag_out expected %0d actual %0d", want.tag, tag_out);
					errors++;
				end
				if (first_out !== want.first) begin
					$error("first_out expected %0d actual %0d", want.first, first_out);
					errors++;
				end
				if (second_out !== want.second) begin
					$error("second_out expected %0d actual %0d", want.second, second_out);
					errors++;
				end
				if (clipped !== want.clip) begin
					$error("clipped expected %0d actual %0d", want.clip, clipped);
					errors++;
				end
			end
		end
		// watchdog on cycles without any transfer or register access
		if (moved || psel) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("FAIL rotary_position_embedding_top");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (addr == AddrTokenPos) cur_position = data[15:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// block drained: nothing waiting on either side, then the pipeline emptied
	task automatic wait_drained();
		while (pending_pairs.size() > 0 || in_valid || rotations_due.size() > 0)
			@(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_random(input int count);
		pair_t it;
		repeat (count) begin
			it.mode = ($urandom_range(0, 7) == 0);
			it.pair_index = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, Pairs - 1));
			it.first_value = pick_value();
			it.second_value = pick_value();
			it.head_tag = 6'($urandom);
			pending_pairs.push_back(it);
		end
	endtask

	initial begin
		logic [15:0] positions [10];
		fill_turn_rate();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: position 0 first, no register write yet
		pending_pairs.push_back({1'b0, 7'd0, 16'sh7FFF, -16'sh8000, 6'd0});
		pending_pairs.push_back({1'b0, 7'd31, 16'sh1000, 16'sh0000, 6'd63});
		wait_drained();

		// directed: position 1 and the largest position, extreme operands
		foreach (positions[i]) positions[i] = 16'($urandom);
		positions[0] = 16'd1;
		positions[1] = 16'hFFFF;
		positions[2] = 16'h8000;
		for (int ph = 0; ph < 2; ph++) begin
			reg_write(AddrTokenPos, {16'($urandom), positions[ph]});
			pending_pairs.push_back({1'b0, 7'd0, 16'sh7FFF, 16'sh7FFF, 6'd1});
			pending_pairs.push_back({1'b0, 7'd0, -16'sh8000, -16'sh8000, 6'd2});
			pending_pairs.push_back({1'b0, 7'd1, -16'sh8000, 16'sh7FFF, 6'd3});
			pending_pairs.push_back({1'b0, 7'd31, 16'sh7FFF, -16'sh8000, 6'd4});
			// index past the pair count passes through
			pending_pairs.push_back({1'b0, 7'd32, 16'sh1234, -16'sh4321, 6'd5});
			pending_pairs.push_back({1'b0, 7'd127, -16'sh8000, 16'sh7FFF, 6'd6});
			// pass-through mode
			pending_pairs.push_back({1'b1, 7'd5, 16'sh7FFF, -16'sh8000, 6'd62});
			pending_pairs.push_back({1'b1, 7'd127, 16'sh0000, 16'sh0001, 6'd63});
			pending_pairs.push_back({1'b0, 7'd16, 16'sh0000, 16'sh0000, 6'd7});
			wait_drained();
		end

		// write to an unused register must leave the position alone
		reg_write(AddrUnused, $urandom);

		// random phases, sender holds off until each phase has drained
		for (int ph = 2; ph < 10; ph++) begin
			if (ph == 9) quiet = 1;
			reg_write(AddrTokenPos, {16'($urandom), positions[ph]});
			queue_random(205);
			wait_drained();
		end

		if (errors == 0) begin
			$display("PASS rotary_position_embedding_top");
		end else begin
			$display("FAIL rotary_position_embedding_top");
		end
		$finish;
	end

endmodule
